// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked through reset as well.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lzss_pkg.sv =====
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Widths, defaults, register indexes and result layout.
// ----------------------------------------------------------------------------
package lzss_pkg;

   localparam int INDEX_BITS_DEF  = 13;
   localparam int LENGTH_BITS_DEF = 4;
   localparam int BYTE_BITS       = 8;

   localparam int MIN_LEN_BITS    = 4;
   localparam int START_POS_BITS  = 13;
   localparam int CFG_DATA_BITS   = 13;
   localparam int CFG_ADDR_BITS   = 1;

   localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_MATCH = 1'b0;
   localparam logic [CFG_ADDR_BITS-1:0] CFG_START_POS = 1'b1;

   localparam logic [MIN_LEN_BITS-1:0]   MIN_LEN_RESET   = 4'd3;
   localparam logic [START_POS_BITS-1:0] START_POS_RESET = 13'd1;

   localparam int MAX_RESULTS = 46;
   localparam int EMIT_BITS   = $clog2(MAX_RESULTS + 1);

   // rsp_tdata: out_byte, stream_done, stream_error, zero fill
   localparam int RSP_DONE_BIT  = BYTE_BITS;
   localparam int RSP_ERR_BIT   = BYTE_BITS + 1;
   localparam int RSP_DATA_BITS = 16;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - BYTE_BITS - 2;

endpackage

// ===== hw/rtl/lzss_bitstream_decompressor.sv =====
// ----------------------------------------------------------------------------
// LZSS bitstream decompressor
// Takes compressed bytes on req_ (one per request, MSB first) and returns the
// decoded bytes on rsp_, one per response, with a status-only response
// closing a stream that ends without a byte. The block takes one input byte
// at a time: it accepts the byte, decodes each flag bit, literal or match
// header in turn, copies each match byte by a window read, then a window
// write and output, and closes the run. Match copies use the single window
// RAM port pair with registered read. Output back-pressure stalls the block.
// The history window is not swept: a fill count since the stream start tells
// which entries were written, and the rest read as zero, so the block is
// ready again right after a stream ends and right after reset.
// ----------------------------------------------------------------------------
module lzss_bitstream_decompressor #(
   parameter int INDEX_BITS  = lzss_pkg::INDEX_BITS_DEF,
   parameter int LENGTH_BITS = lzss_pkg::LENGTH_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lzss_pkg::BYTE_BITS-1:0]       req_tdata,   // [7:0] in_byte
   input  logic                                 req_tlast,   // in_last
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lzss_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // [7:0] out_byte,
                                                             // [8] stream_done,
                                                             // [9] stream_error
   output logic                                 rsp_tuser,   // byte_valid
   output logic                                 rsp_tlast,   // run_last
   input  logic                                 csr_we,
   input  logic [lzss_pkg::CFG_ADDR_BITS-1:0]   csr_addr,
   input  logic [lzss_pkg::CFG_DATA_BITS-1:0]   csr_wdata
);

   localparam int TOKEN_BITS = INDEX_BITS + LENGTH_BITS;
   localparam int ACC_BITS   = TOKEN_BITS + lzss_pkg::BYTE_BITS - 1;
   localparam int HELD_BITS  = $clog2(ACC_BITS + 1);
   localparam int SHIFT_W    = ACC_BITS + TOKEN_BITS;
   localparam int SHAMT_BITS = $clog2(SHIFT_W);
   localparam int WIN_DEPTH  = 1 << INDEX_BITS;
   localparam int FILL_BITS  = INDEX_BITS + 1;
   localparam int CNT_BITS   = ((LENGTH_BITS > lzss_pkg::MIN_LEN_BITS) ?
                                LENGTH_BITS : lzss_pkg::MIN_LEN_BITS) + 1;
   localparam int BB         = lzss_pkg::BYTE_BITS;
   localparam int EB         = lzss_pkg::EMIT_BITS;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DECODE  = 3'd1;
   localparam logic [2:0] ST_COPY_RD = 3'd2;
   localparam logic [2:0] ST_COPY_WR = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   localparam logic [1:0] PH_FLAG = 2'd0;
   localparam logic [1:0] PH_LIT  = 2'd1;
   localparam logic [1:0] PH_POS  = 2'd2;

   logic [2:0]                          state_ff, state_in;
   logic [1:0]                          phase_ff, phase_in;
   logic [ACC_BITS-1:0]                 acc_ff, acc_in;
   logic [HELD_BITS-1:0]                held_ff, held_in;
   logic                                ended_ff, ended_in;
   logic                                trail_ff, trail_in;
   logic                                open_ff, open_in;
   logic                                last_ff, last_in;
   logic [INDEX_BITS-1:0]               wpos_ff, wpos_in;
   logic [INDEX_BITS-1:0]               start_ff, start_in;
   logic [FILL_BITS-1:0]                fill_ff, fill_in;
   logic [INDEX_BITS-1:0]               rpos_ff, rpos_in;
   logic [CNT_BITS-1:0]                 cnt_ff, cnt_in;
   logic [EB-1:0]                       emit_cnt_ff, emit_cnt_in;
   logic                                rd_ok_ff, rd_ok_in;
   logic                                pend_valid_ff, pend_valid_in;
   logic [BB-1:0]                       pend_byte_ff, pend_byte_in;
   logic                                out_valid_ff, out_valid_in;
   logic [BB-1:0]                       out_byte_ff, out_byte_in;
   logic                                out_bv_ff, out_bv_in;
   logic                                out_last_ff, out_last_in;
   logic                                out_done_ff, out_done_in;
   logic                                out_err_ff, out_err_in;
   logic [lzss_pkg::MIN_LEN_BITS-1:0]   min_len_ff, min_len_in;
   logic [lzss_pkg::START_POS_BITS-1:0] start_cfg_ff, start_cfg_in;

   logic [HELD_BITS-1:0]  k_need;
   logic [SHAMT_BITS-1:0] shamt;
   logic [SHIFT_W-1:0]    shifted;
   logic [TOKEN_BITS-1:0] field;
   logic                  have;
   logic                  have_idx;
   logic [HELD_BITS-1:0]  held_after;
   logic [ACC_BITS-1:0]   acc_keep;
   logic [INDEX_BITS-1:0] pos_fld;
   logic [CNT_BITS-1:0]   copy_count;
   logic [INDEX_BITS-1:0] rel_pos;
   logic                  out_free;
   logic                  can_emit;
   logic                  emit_go;
   logic [BB-1:0]         emit_byte;
   logic                  ram_we;
   logic                  ram_re;
   logic [BB-1:0]         ram_rdata;

   // Token field extraction: one right shifter over the zero-extended
   // accumulator, which also supplies the zero padding of a short final token.
   always_comb begin
      unique case (phase_ff)
         PH_FLAG: k_need = HELD_BITS'(1);
         PH_LIT:  k_need = HELD_BITS'(BB);
         default: k_need = HELD_BITS'(TOKEN_BITS);
      endcase
      shamt      = SHAMT_BITS'(held_ff) + SHAMT_BITS'(TOKEN_BITS) - SHAMT_BITS'(k_need);
      shifted    = {acc_ff, TOKEN_BITS'(0)} >> shamt;
      field      = shifted[TOKEN_BITS-1:0];
      have       = (held_ff >= k_need);
      have_idx   = (held_ff >= HELD_BITS'(INDEX_BITS));
      held_after = have ? (held_ff - k_need) : '0;
      for (int i = 0; i < ACC_BITS; i++) begin
         acc_keep[i] = (HELD_BITS'(i) < held_after);
      end
      pos_fld    = field[TOKEN_BITS-1:LENGTH_BITS];
      copy_count = CNT_BITS'(field[LENGTH_BITS-1:0]) + CNT_BITS'(min_len_ff);
      rel_pos    = rpos_ff - start_ff;
      out_free   = !out_valid_ff || rsp_tready;
      can_emit   = !pend_valid_ff || out_free;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      held_in       = held_ff;
      ended_in      = ended_ff;
      trail_in      = trail_ff;
      open_in       = open_ff;
      last_in       = last_ff;
      wpos_in       = wpos_ff;
      start_in      = start_ff;
      fill_in       = fill_ff;
      rpos_in       = rpos_ff;
      cnt_in        = cnt_ff;
      emit_cnt_in   = emit_cnt_ff;
      rd_ok_in      = rd_ok_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_bv_in     = out_bv_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      out_err_in    = out_err_ff;
      min_len_in    = min_len_ff;
      start_cfg_in  = start_cfg_ff;
      emit_go       = 1'b0;
      emit_byte     = '0;
      ram_re        = 1'b0;

      if (rsp_tvalid && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_addr)
            lzss_pkg::CFG_MIN_MATCH: min_len_in   = csr_wdata[lzss_pkg::MIN_LEN_BITS-1:0];
            lzss_pkg::CFG_START_POS: start_cfg_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               emit_cnt_in = '0;
               last_in     = req_tlast;
               if (!open_ff) begin
                  open_in  = 1'b1;
                  wpos_in  = INDEX_BITS'(start_cfg_ff);
                  start_in = INDEX_BITS'(start_cfg_ff);
                  fill_in  = '0;
               end
               if (ended_ff) begin
                  trail_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  acc_in   = {acc_ff[ACC_BITS-BB-1:0], req_tdata};
                  held_in  = held_ff + HELD_BITS'(BB);
                  state_in = ST_DECODE;
               end
            end
         end
         ST_DECODE: begin
            unique case (phase_ff)
               PH_FLAG: begin
                  if (!have && !last_ff) begin
                     state_in = ST_FINISH;
                  end else begin
                     phase_in = field[0] ? PH_LIT : PH_POS;
                     held_in  = held_after;
                     acc_in   = acc_ff & acc_keep;
                  end
               end
               PH_LIT: begin
                  if (!have && !last_ff) begin
                     state_in = ST_FINISH;
                  end else if (can_emit) begin
                     emit_go   = 1'b1;
                     emit_byte = field[BB-1:0];
                     held_in   = held_after;
                     acc_in    = acc_ff & acc_keep;
                     phase_in  = PH_FLAG;
                  end
               end
               PH_POS: begin
                  if (!have_idx && !last_ff) begin
                     state_in = ST_FINISH;
                  end else if (pos_fld == '0) begin
                     ended_in = 1'b1;
                     if (held_ff > HELD_BITS'(INDEX_BITS)) begin
                        trail_in = 1'b1;
                     end
                     acc_in   = '0;
                     held_in  = '0;
                     phase_in = PH_FLAG;
                     state_in = ST_FINISH;
                  end else if (!have && !last_ff) begin
                     state_in = ST_FINISH;
                  end else begin
                     held_in  = held_after;
                     acc_in   = acc_ff & acc_keep;
                     rpos_in  = pos_fld;
                     cnt_in   = copy_count;
                     phase_in = PH_FLAG;
                     state_in = (copy_count == '0) ? ST_DECODE : ST_COPY_RD;
                  end
               end
               default: phase_in = PH_FLAG;
            endcase
         end
         ST_COPY_RD: begin
            ram_re   = 1'b1;
            rd_ok_in = ({1'b0, rel_pos} < fill_ff);
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            if (can_emit) begin
               emit_go   = 1'b1;
               emit_byte = rd_ok_ff ? ram_rdata : '0;
               rpos_in   = rpos_ff + INDEX_BITS'(1);
               cnt_in    = cnt_ff - CNT_BITS'(1);
               state_in  = (cnt_ff == CNT_BITS'(1)) ? ST_DECODE : ST_COPY_RD;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_byte_in  = pend_byte_ff;
                  out_bv_in    = 1'b1;
                  out_last_in  = 1'b1;
                  out_done_in  = last_ff;
                  out_err_in   = last_ff && trail_ff;
               end else if (last_ff) begin
                  out_valid_in = 1'b1;
                  out_byte_in  = '0;
                  out_bv_in    = 1'b0;
                  out_last_in  = 1'b1;
                  out_done_in  = 1'b1;
                  out_err_in   = trail_ff;
               end
               pend_valid_in = 1'b0;
               if (last_ff) begin
                  acc_in   = '0;
                  held_in  = '0;
                  phase_in = PH_FLAG;
                  ended_in = 1'b0;
                  trail_in = 1'b0;
                  open_in  = 1'b0;
                  fill_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Hold back the newest byte so the run's final response can carry run_last.
      if (emit_go) begin
         wpos_in = wpos_ff + INDEX_BITS'(1);
         if (fill_ff != FILL_BITS'(WIN_DEPTH)) begin
            fill_in = fill_ff + FILL_BITS'(1);
         end
         if (emit_cnt_ff < EB'(lzss_pkg::MAX_RESULTS)) begin
            emit_cnt_in = emit_cnt_ff + EB'(1);
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_byte_in  = pend_byte_ff;
               out_bv_in    = 1'b1;
               out_last_in  = 1'b0;
               out_done_in  = 1'b0;
               out_err_in   = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_byte_in  = emit_byte;
         end
      end
   end

   assign ram_we = emit_go;

   lzss_ram #(
      .WIDTH (BB),
      .DEPTH (WIN_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wpos_ff),
      .wr_data (emit_byte),
      .rd_en   (ram_re),
      .rd_addr (rpos_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_FLAG;
         acc_ff        <= '0;
         held_ff       <= '0;
         ended_ff      <= 1'b0;
         trail_ff      <= 1'b0;
         open_ff       <= 1'b0;
         fill_ff       <= '0;
         emit_cnt_ff   <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         min_len_ff    <= lzss_pkg::MIN_LEN_RESET;
         start_cfg_ff  <= lzss_pkg::START_POS_RESET;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         held_ff       <= held_in;
         ended_ff      <= ended_in;
         trail_ff      <= trail_in;
         open_ff       <= open_in;
         fill_ff       <= fill_in;
         emit_cnt_ff   <= emit_cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         min_len_ff    <= min_len_in;
         start_cfg_ff  <= start_cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      wpos_ff      <= wpos_in;
      start_ff     <= start_in;
      rpos_ff      <= rpos_in;
      cnt_ff       <= cnt_in;
      rd_ok_ff     <= rd_ok_in;
      pend_byte_ff <= pend_byte_in;
      out_byte_ff  <= out_byte_in;
      out_bv_ff    <= out_bv_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
      out_err_ff   <= out_err_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{lzss_pkg::RSP_PAD_BITS{1'b0}}, out_err_ff, out_done_ff, out_byte_ff};
   assign rsp_tuser  = out_bv_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hw/rtl/lzss_ram.sv =====
// ----------------------------------------------------------------------------
// LZSS generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzss_ram #(
   parameter int WIDTH = lzss_pkg::BYTE_BITS,
   parameter int DEPTH = 1 << lzss_pkg::INDEX_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lzss_chk.sv =====
// ----------------------------------------------------------------------------
// LZSS decompressor port checker
// Watches the request and response ports of the decompressor over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzss_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lzss_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast
);

   `CHK_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> req_tready && !rsp_tvalid, "not idle after reset")

   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   `CHK_ASSERT(a_status_only, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[lzss_pkg::RSP_DONE_BIT] && (rsp_tdata[lzss_pkg::BYTE_BITS-1:0] == '0), "bad status-only response")

   `CHK_ASSERT(a_done_last, clock, reset, rsp_tvalid && rsp_tdata[lzss_pkg::RSP_DONE_BIT] |-> rsp_tlast, "stream end without run end")

   `CHK_ASSERT(a_err_done, clock, reset, rsp_tvalid && rsp_tdata[lzss_pkg::RSP_ERR_BIT] |-> rsp_tdata[lzss_pkg::RSP_DONE_BIT], "error outside stream end")

endmodule

bind lzss_bitstream_decompressor lzss_chk u_lzss_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZSS bitstream decompressor testbench
// Builds compressed streams from literal, match and end-marker tokens, sends
// them byte by byte with random gaps on both sides, and checks every decoded
// byte and every stream status against a software copy of the decoder, its
// bit accumulator and its history window. Covers padded and truncated final
// bytes, bytes after the end marker, wrapping copies and register extremes.
// ----------------------------------------------------------------------------
module tb;

   localparam int WIN_BITS   = lzss_pkg::INDEX_BITS_DEF;
   localparam int LEN_BITS   = lzss_pkg::LENGTH_BITS_DEF;
   localparam int WIN_SIZE   = 1 << WIN_BITS;
   localparam int IDLE_LIMIT = 4000;

   typedef enum logic [1:0] {PH_FLAG, PH_LITERAL, PH_POSITION} token_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       run_end;
      logic       done;
      logic       err;
   } decoded_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [lzss_pkg::BYTE_BITS-1:0]      req_tdata;
   logic                                req_tlast;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [lzss_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                                rsp_tuser;
   logic                                rsp_tlast;
   logic                                csr_we;
   logic [lzss_pkg::CFG_ADDR_BITS-1:0]  csr_addr;
   logic [lzss_pkg::CFG_DATA_BITS-1:0]  csr_wdata;

   lzss_bitstream_decompressor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // decoder copy
   logic [lzss_pkg::MIN_LEN_BITS-1:0]   min_len;
   logic [lzss_pkg::START_POS_BITS-1:0] start_pos;
   logic [7:0]                history [WIN_SIZE];
   logic [WIN_BITS-1:0]       hist_wr;
   logic [31:0]               acc;
   int unsigned               acc_bits;
   token_phase_type           phase;
   bit                        marker_seen;
   bit                        trailing;
   bit                        stream_open;
   decoded_type               step_q[$];
   decoded_type               decoded_q[$];

   // stimulus and bookkeeping
   logic                      token_bits[$];
   bit                        steady = 1'b0;
   int                        requests_sent = 0;
   int                        streams_done = 0;
   int                        bytes_checked = 0;
   int                        ends_checked = 0;
   int                        mismatches = 0;
   int                        idle_cycles = 0;

   function automatic logic [31:0] peek_bits(int unsigned n);
      return (acc >> (acc_bits - n)) & ((32'd1 << n) - 1);
   endfunction

   function automatic logic [31:0] take_bits(int unsigned n);
      logic [31:0] v;
      v = peek_bits(n);
      acc_bits -= n;
      acc &= (32'd1 << acc_bits) - 1;
      return v;
   endfunction

   function automatic void pad_bits(int unsigned n);
      if (acc_bits < n) begin
         acc = acc << (n - acc_bits);
         acc_bits = n;
      end
   endfunction

   function automatic void emit(logic [7:0] b);
      history[hist_wr] = b;
      hist_wr++;
      if (step_q.size() < lzss_pkg::MAX_RESULTS) begin
         step_q.insert(step_q.size(), decoded_type'{b, 1'b1, 1'b0, 1'b0, 1'b0});
      end
   endfunction

   function automatic void clear_stream();
      foreach (history[i]) history[i] = 8'h00;
      hist_wr = start_pos;
      acc = '0;
      acc_bits = 0;
      phase = PH_FLAG;
      marker_seen = 1'b0;
      trailing = 1'b0;
      stream_open = 1'b0;
   endfunction

   // Run tokens until the bits run out; on the final byte, pad with zeros.
   function automatic void decode_tokens(bit last);
      logic [WIN_BITS-1:0] pos;
      int unsigned count;
      forever begin
         case (phase)
            PH_FLAG: begin
               if (acc_bits < 1) begin
                  if (!last) return;
                  pad_bits(1);
               end
               phase = (take_bits(1) != 0) ? PH_LITERAL : PH_POSITION;
            end
            PH_LITERAL: begin
               if (acc_bits < 8) begin
                  if (!last) return;
                  pad_bits(8);
               end
               emit(8'(take_bits(8)));
               phase = PH_FLAG;
            end
            default: begin
               if (acc_bits < WIN_BITS) begin
                  if (!last) return;
                  pad_bits(WIN_BITS);
               end
               if (peek_bits(WIN_BITS) == 0) begin
                  void'(take_bits(WIN_BITS));
                  marker_seen = 1'b1;
                  if (acc_bits > 0) trailing = 1'b1;
                  acc_bits = 0;
                  acc = '0;
                  phase = PH_FLAG;
                  return;
               end
               if (acc_bits < WIN_BITS + LEN_BITS) begin
                  if (!last) return;
                  pad_bits(WIN_BITS + LEN_BITS);
               end
               pos = WIN_BITS'(take_bits(WIN_BITS));
               count = take_bits(LEN_BITS) + min_len;
               repeat (count) begin
                  emit(history[pos]);
                  pos++;
               end
               phase = PH_FLAG;
            end
         endcase
      end
   endfunction

   function automatic void decode_request(logic [7:0] in_byte, bit last);
      decoded_type r;
      step_q.delete();
      if (!stream_open) begin
         stream_open = 1'b1;
         hist_wr = start_pos;
      end
      if (marker_seen) begin
         trailing = 1'b1;
      end else begin
         acc = (acc << 8) | in_byte;
         acc_bits += 8;
         decode_tokens(last);
      end
      if (step_q.size() == 0 && last) step_q.insert(0, decoded_type'(0));
      if (step_q.size() > 0) begin
         r = step_q[step_q.size() - 1];
         r.run_end = 1'b1;
         if (last) begin
            r.done = 1'b1;
            r.err = trailing;
         end
         step_q[step_q.size() - 1] = r;
      end
      if (last) begin
         clear_stream();
         streams_done++;
      end
      foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
   endfunction

   function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_result();
      decoded_type want;
      if (decoded_q.size() == 0) begin
         $error("unexpected result: tdata=%h tuser=%b tlast=%b", rsp_tdata, rsp_tuser,
                rsp_tlast);
         mismatches++;
      end else begin
         want = decoded_q.pop_front();
         compare_field("out_byte", want.data, rsp_tdata[lzss_pkg::BYTE_BITS-1:0]);
         compare_field("byte_valid", want.valid, rsp_tuser);
         compare_field("run_last", want.run_end, rsp_tlast);
         compare_field("stream_done", want.done, rsp_tdata[lzss_pkg::RSP_DONE_BIT]);
         compare_field("stream_error", want.err, rsp_tdata[lzss_pkg::RSP_ERR_BIT]);
         if (want.valid) bytes_checked++;
         if (want.done) ends_checked++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      rsp_tready <= steady || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("lzss_bitstream_decompressor test failed");
         $finish;
      end
   end

   // Hold valid high from one request to the next; drop it only to idle.
   task automatic send_request(logic [7:0] in_byte, bit last);
      while (!steady && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= in_byte;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      decode_request(in_byte, last);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_register(logic [lzss_pkg::CFG_ADDR_BITS-1:0] idx,
                                 logic [lzss_pkg::CFG_DATA_BITS-1:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == lzss_pkg::CFG_MIN_MATCH) min_len = value[lzss_pkg::MIN_LEN_BITS-1:0];
      else start_pos = value[lzss_pkg::START_POS_BITS-1:0];
   endtask

   function automatic void push_field(logic [15:0] value, int n);
      for (int i = n - 1; i >= 0; i--) token_bits.insert(token_bits.size(), value[i]);
   endfunction

   function automatic void push_literal(logic [7:0] b);
      push_field(16'd1, 1);
      push_field(16'(b), 8);
   endfunction

   function automatic void push_match(logic [WIN_BITS-1:0] pos, logic [LEN_BITS-1:0] len);
      push_field(16'd0, 1);
      push_field(16'(pos), WIN_BITS);
      push_field(16'(len), LEN_BITS);
   endfunction

   function automatic void push_end();
      push_field(16'd0, 1 + WIN_BITS);
   endfunction

   // Pack the token bits MSB first, pad with zeros, append stray bytes.
   task automatic send_token_bits(int extra);
      int nbytes;
      logic [7:0] b;
      while (token_bits.size() % 8 != 0) token_bits.insert(token_bits.size(), 1'b0);
      nbytes = token_bits.size() / 8;
      for (int i = 0; i < nbytes; i++) begin
         for (int j = 0; j < 8; j++) b[7-j] = token_bits[8*i+j];
         send_request(b, extra == 0 && i == nbytes - 1);
      end
      token_bits.delete();
      for (int i = 0; i < extra; i++) send_request(8'($urandom), i == extra - 1);
   endtask

   task automatic random_stream(int ntok);
      logic [WIN_BITS-1:0] wr;
      logic [WIN_BITS-1:0] pos;
      logic [LEN_BITS-1:0] len;
      int written;
      int back;
      int kind;
      int keep;
      wr = start_pos;
      written = 0;
      kind = $urandom_range(99);
      repeat (ntok) begin
         if (written == 0 || $urandom_range(1) == 0) begin
            push_literal(8'($urandom));
            wr++;
            written++;
         end else begin
            len = LEN_BITS'($urandom);
            if ($urandom_range(3) == 0) begin
               pos = WIN_BITS'($urandom_range(WIN_SIZE - 1, 1));
            end else begin
               back = $urandom_range(written < 40 ? written : 40, 1);
               pos = wr - WIN_BITS'(back);
            end
            if (pos == 0) pos = 1;
            push_match(pos, len);
            wr = wr + len + min_len;
            written += len + min_len;
         end
      end
      if (kind < 15) begin
         keep = $urandom_range(token_bits.size(), 1);
         while (token_bits.size() > keep) void'(token_bits.pop_back());
         send_token_bits(0);
      end else begin
         push_end();
         send_token_bits(kind < 30 ? $urandom_range(3, 1) : 0);
      end
   endtask

   task automatic test_literals();
      push_literal(8'h00);
      push_literal(8'hFF);
      push_end();
      send_token_bits(0);
      push_literal(8'hA5);
      push_end();
      send_token_bits(0);
   endtask

   task automatic test_match_copy();
      push_literal(8'h41);
      push_literal(8'h42);
      push_match(13'd1, 4'd0);
      push_match(13'd2, 4'd15);
      push_match(13'h1F00, 4'd4);
      push_end();
      send_token_bits(0);
   endtask

   task automatic test_stream_ends();
      send_request(8'h00, 1'b1);
      push_literal(8'h3C);
      push_match(13'h1FFF, 4'd9);
      while (token_bits.size() > 12) void'(token_bits.pop_back());
      send_token_bits(0);
      push_literal(8'h5A);
      push_literal(8'h81);
      push_end();
      send_token_bits(2);
   endtask

   task automatic test_registers();
      write_register(lzss_pkg::CFG_MIN_MATCH, 13'h1FFF);
      push_literal(8'h5E);
      push_match(13'd1, 4'd15);
      push_end();
      send_token_bits(0);
      write_register(lzss_pkg::CFG_MIN_MATCH, 13'h0000);
      push_literal(8'h11);
      push_match(13'd1, 4'd0);
      push_match(13'd1, 4'd2);
      push_end();
      send_token_bits(0);
      write_register(lzss_pkg::CFG_START_POS, 13'h1FFF);
      push_literal(8'hC3);
      push_literal(8'h7E);
      push_literal(8'h24);
      push_match(13'h1FFF, 4'd5);
      push_end();
      send_token_bits(0);
      random_stream(8);
      write_register(lzss_pkg::CFG_START_POS, 13'h0000);
      random_stream(6);
   endtask

   task automatic test_random_streams();
      int streams;
      streams = 0;
      while (requests_sent < 160) begin
         if ($urandom_range(3) == 0) write_register(lzss_pkg::CFG_MIN_MATCH, 13'($urandom));
         if ($urandom_range(3) == 0) write_register(lzss_pkg::CFG_START_POS, 13'($urandom));
         steady = (streams >= 2 && streams < 5);
         random_stream($urandom_range(12, 2));
         streams++;
      end
      steady = 1'b0;
   endtask

   task automatic test_noise();
      repeat (24) send_request(8'($urandom), $urandom_range(5) == 0);
      send_request(8'($urandom), 1'b1);
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      rsp_tready <= 1'b0;
      csr_we <= 1'b0;
      csr_addr <= lzss_pkg::CFG_MIN_MATCH;
      csr_wdata <= '0;
      min_len = lzss_pkg::MIN_LEN_RESET;
      start_pos = lzss_pkg::START_POS_RESET;
      clear_stream();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_literals();
      test_match_copy();
      test_stream_ends();
      test_registers();
      test_random_streams();
      test_noise();
      wait_drained();
      repeat (60) @(posedge clock);
      $display("Sent %0d compressed bytes in %0d streams across several register settings.",
               requests_sent, streams_done);
      $display("Checked %0d decoded bytes and %0d stream ends.", bytes_checked, ends_checked);
      if (mismatches == 0) begin
         $display("lzss_bitstream_decompressor test passed");
      end else begin
         $display("lzss_bitstream_decompressor test failed");
      end
      $finish;
   end

endmodule
